>>> rtl/core/flr_pkg.sv
// Package with the command codes, record type and helper functions of the fault latch recorder.
`default_nettype none

package flr_pkg;

    localparam int unsigned STORE_DEPTH = 32;
    localparam int unsigned ADDR_W = 5;
    localparam logic [5:0] MAX_CODE = 6'd31;

    localparam int unsigned IN_W = 40;
    localparam int unsigned OUT_W = 264;

    typedef enum logic [1:0] {
        CMD_RAISE     = 2'd0,
        CMD_CLEAR     = 2'd1,
        CMD_CLEAR_ALL = 2'd2,
        CMD_READ      = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [31:0] latest_time;
        logic [31:0] latest_seq;
        logic [31:0] first_time;
        logic [31:0] first_seq;
        logic [31:0] count;
    } rec_t;

    function automatic logic code_valid(input logic [ADDR_W-1:0] code);
        code_valid = (code != '0) && ({1'b0, code} <= MAX_CODE);
    endfunction

    function automatic logic [ADDR_W-1:0] lowest_active(input logic [31:0] mask);
        logic [ADDR_W-1:0] c;
        c = '0;
        for (int i = STORE_DEPTH - 1; i >= 1; i--) begin
            if (mask[i] && (6'(i) <= MAX_CODE)) begin
                c = ADDR_W'(i);
            end
        end
        lowest_active = c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/fault_latch_recorder_top.sv
// Fault latch recorder: fault masks, primary fault, event sequence and per-code records.
// An accepted request runs in ST_EXEC; its result is registered once the output register is free.
// A new request is taken only in ST_IDLE, after the record read and write-back of the last one.
// A new request is taken while a finished result still waits in the output register.
// Reset clears the masks, the primary code, the sequence and all record valid bits at once,
// so every record reads as zero until its code is raised again.
`default_nettype none

module fault_latch_recorder_top (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // cmd[1:0], code[6:2], obs_present[7], obs_time_ms[39:8]
    input  wire logic [flr_pkg::IN_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // ok[0], active_mask[32:1], latched_mask[64:33], primary_code[69:65],
    // sequence_now[101:70], rec_count[133:102], rec_first_seq[165:134],
    // rec_first_time[197:166], rec_latest_seq[229:198], rec_latest_time[261:230], zero pad
    output logic [flr_pkg::OUT_W-1:0]        m_tdata
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                      state_reg;
    logic                        m_tvalid_reg;
    logic [flr_pkg::OUT_W-1:0]   m_tdata_reg;
    logic [flr_pkg::OUT_W-1:0]   m_tdata_next;

    logic [31:0]                 active_reg, active_next;
    logic [31:0]                 latched_reg, latched_next;
    logic [flr_pkg::ADDR_W-1:0]  primary_reg, primary_next;
    logic [31:0]                 seq_reg, seq_next;
    logic [flr_pkg::STORE_DEPTH-1:0] entry_valid_reg;

    flr_pkg::cmd_t               cmd_reg;
    logic [flr_pkg::ADDR_W-1:0]  code_reg;
    logic                        obs_reg;
    logic [31:0]                 time_reg;
    logic                        hit_reg;

    flr_pkg::rec_t               mem [flr_pkg::STORE_DEPTH];
    flr_pkg::rec_t               rd_data_reg;
    flr_pkg::rec_t               rec_cur;
    flr_pkg::rec_t               rec_next;
    flr_pkg::rec_t               rec_out;

    logic                        s_fire;
    logic                        done;
    logic                        wr_en;
    logic                        valid_code;
    logic                        ok;
    logic                        is_new;
    logic [31:0]                 code_bit;
    logic [31:0]                 seq_inc;
    logic [flr_pkg::ADDR_W-1:0]  in_code;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign done     = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign in_code  = s_tdata[6:2];

    always_comb begin
        valid_code   = flr_pkg::code_valid(code_reg);
        code_bit     = 32'd1 << code_reg;
        rec_cur      = hit_reg ? rd_data_reg : '0;
        rec_next     = rec_cur;
        active_next  = active_reg;
        latched_next = latched_reg;
        primary_next = primary_reg;
        seq_next     = seq_reg;
        ok           = valid_code;
        is_new       = 1'b0;
        wr_en        = 1'b0;
        seq_inc      = seq_reg + 32'd1;
        unique case (cmd_reg)
            flr_pkg::CMD_RAISE: begin
                if (valid_code) begin
                    is_new = ((active_reg & code_bit) == '0);
                    if (is_new) begin
                        seq_next = (seq_inc == '0) ? 32'd1 : seq_inc;
                        if (rec_cur.count != '1) begin
                            rec_next.count = rec_cur.count + 32'd1;
                        end
                        if (rec_cur.first_seq == '0) begin
                            rec_next.first_seq  = seq_next;
                            rec_next.first_time = obs_reg ? time_reg : '0;
                        end
                        rec_next.latest_seq = seq_next;
                        if (obs_reg) begin
                            rec_next.latest_time = time_reg;
                        end
                        wr_en = done;
                    end
                    active_next  = active_reg | code_bit;
                    latched_next = latched_reg | code_bit;
                    primary_next = flr_pkg::lowest_active(active_next);
                end
            end
            flr_pkg::CMD_CLEAR: begin
                if (valid_code) begin
                    active_next  = active_reg & ~code_bit;
                    primary_next = flr_pkg::lowest_active(active_next);
                end
            end
            flr_pkg::CMD_CLEAR_ALL: begin
                ok           = 1'b1;
                active_next  = '0;
                latched_next = '0;
                primary_next = '0;
            end
            flr_pkg::CMD_READ: begin
            end
        endcase
        rec_out      = valid_code ? rec_next : '0;
        m_tdata_next = {2'b00, rec_out.latest_time, rec_out.latest_seq, rec_out.first_time,
                        rec_out.first_seq, rec_out.count, seq_next, primary_next,
                        latched_next, active_next, ok};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            active_reg      <= '0;
            latched_reg     <= '0;
            primary_reg     <= '0;
            seq_reg         <= '0;
            entry_valid_reg <= '0;
        end else begin
            if (m_tready && !done) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg   <= flr_pkg::cmd_t'(s_tdata[1:0]);
                        code_reg  <= in_code;
                        obs_reg   <= s_tdata[7];
                        time_reg  <= s_tdata[39:8];
                        hit_reg   <= entry_valid_reg[in_code];
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (done) begin
                        active_reg   <= active_next;
                        latched_reg  <= latched_next;
                        primary_reg  <= primary_next;
                        seq_reg      <= seq_next;
                        m_tdata_reg  <= m_tdata_next;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                        if (wr_en) begin
                            entry_valid_reg[code_reg] <= 1'b1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rd_data_reg <= mem[in_code];
        end
        if (wr_en) begin
            mem[code_reg] <= rec_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/flr_checker.sv
// Port-level checker for the fault latch recorder and its bind to the top level.
`default_nettype none

module flr_checker (
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_tvalid,
    input wire logic                     s_tready,
    input wire logic                     m_tvalid,
    input wire logic                     m_tready,
    input wire logic [flr_pkg::OUT_W-1:0] m_tdata
);

    // A held result must not change while it waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A rejected request shows an empty record.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> (m_tdata[261:102] == '0))
        else $error("rejected request shows record data");

    // Active faults are always latched, and code zero is never active.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[1] && ((m_tdata[32:1] & ~m_tdata[64:33]) == '0))
        else $error("active mask inconsistent with latched mask");

    // No primary fault without an active fault.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[32:1] == '0) |-> (m_tdata[69:65] == '0))
        else $error("primary code set with no active fault");

    // A request is executed before the next one is taken, so requests are never accepted back to back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("requests accepted back to back");

endmodule

bind fault_latch_recorder_top flr_checker u_flr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> dv/fault_latch_recorder_top_test.sv
// Self-checking testbench for the fault latch recorder: directed, random and back-pressure tests.
`default_nettype none

module fault_latch_recorder_top_test;

    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]    pad;
        flr_pkg::rec_t rec;
        logic [31:0]   sequence_now;
        logic [4:0]    primary_code;
        logic [31:0]   latched_mask;
        logic [31:0]   active_mask;
        logic          ok;
    } fault_status_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [flr_pkg::IN_W-1:0]   s_tdata = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [flr_pkg::OUT_W-1:0]  m_tdata;

    logic              rx_hold = 1'b0;
    int unsigned       tx_idle_pct = 0;
    int unsigned       rx_stall_pct = 0;
    int unsigned       mismatch_count = 0;
    int unsigned       cycle_count = 0;

    logic [31:0]       model_active = '0;
    logic [31:0]       model_latched = '0;
    logic [4:0]        model_primary = '0;
    logic [31:0]       event_seq = '0;
    flr_pkg::rec_t     fault_records [32] = '{default: '0};
    fault_status_t     pending_status [$];

    fault_latch_recorder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    function automatic logic [4:0] lowest_set_code(input logic [31:0] mask);
        logic [4:0] found;
        found = '0;
        for (int c = 31; c >= 1; c--) begin
            if (mask[c] && (6'(c) <= flr_pkg::MAX_CODE)) begin
                found = 5'(c);
            end
        end
        return found;
    endfunction

    task automatic predict_status(input flr_pkg::cmd_t cmd, input logic [4:0] code,
                                  input logic obs, input logic [31:0] stamp);
        fault_status_t want;
        logic          valid;
        logic [31:0]   code_bit;
        want = '0;
        valid = (code != '0) && ({1'b0, code} <= flr_pkg::MAX_CODE);
        code_bit = 32'd1 << code;
        if (cmd == flr_pkg::CMD_CLEAR_ALL) begin
            model_active = '0;
            model_latched = '0;
            model_primary = '0;
            want.ok = 1'b1;
        end else if (valid) begin
            want.ok = 1'b1;
            if (cmd == flr_pkg::CMD_RAISE) begin
                if ((model_active & code_bit) == '0) begin
                    event_seq = event_seq + 32'd1;
                    if (event_seq == '0) begin
                        event_seq = 32'd1;
                    end
                    if (fault_records[code].count != '1) begin
                        fault_records[code].count = fault_records[code].count + 32'd1;
                    end
                    if (fault_records[code].first_seq == '0) begin
                        fault_records[code].first_seq = event_seq;
                        fault_records[code].first_time = obs ? stamp : 32'd0;
                    end
                    fault_records[code].latest_seq = event_seq;
                    if (obs) begin
                        fault_records[code].latest_time = stamp;
                    end
                end
                model_active |= code_bit;
                model_latched |= code_bit;
                model_primary = lowest_set_code(model_active);
            end else if (cmd == flr_pkg::CMD_CLEAR) begin
                model_active &= ~code_bit;
                model_primary = lowest_set_code(model_active);
            end
        end
        want.active_mask = model_active;
        want.latched_mask = model_latched;
        want.primary_code = model_primary;
        want.sequence_now = event_seq;
        want.rec = valid ? fault_records[code] : '0;
        pending_status.push_back(want);
    endtask

    task automatic send_request(input flr_pkg::cmd_t cmd, input logic [4:0] code,
                                input logic obs, input logic [31:0] stamp);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {stamp, obs, code, cmd};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        predict_status(cmd, code, obs, stamp);
    endtask

    task automatic send_random_request();
        flr_pkg::cmd_t cmd;
        logic [4:0]    code;
        int unsigned   roll;
        roll = $urandom_range(99);
        if (roll < 45) begin
            cmd = flr_pkg::CMD_RAISE;
        end else if (roll < 75) begin
            cmd = flr_pkg::CMD_CLEAR;
        end else if (roll < 94) begin
            cmd = flr_pkg::CMD_READ;
        end else begin
            cmd = flr_pkg::CMD_CLEAR_ALL;
        end
        roll = $urandom_range(99);
        if (roll < 4) begin
            code = '0;
        end else if (roll < 40) begin
            code = 5'($urandom_range(1, 4));
        end else begin
            code = 5'($urandom_range(1, 31));
        end
        send_request(cmd, code, 1'($urandom_range(1)), $urandom);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic compare_field(input string field_name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field_name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_status(input fault_status_t got);
        fault_status_t want;
        if (pending_status.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            mismatch_count++;
        end else begin
            want = pending_status.pop_front();
            compare_field("ok", 32'(want.ok), 32'(got.ok));
            compare_field("active_mask", want.active_mask, got.active_mask);
            compare_field("latched_mask", want.latched_mask, got.latched_mask);
            compare_field("primary_code", 32'(want.primary_code), 32'(got.primary_code));
            compare_field("sequence_now", want.sequence_now, got.sequence_now);
            compare_field("rec_count", want.rec.count, got.rec.count);
            compare_field("rec_first_seq", want.rec.first_seq, got.rec.first_seq);
            compare_field("rec_first_time", want.rec.first_time, got.rec.first_time);
            compare_field("rec_latest_seq", want.rec.latest_seq, got.rec.latest_seq);
            compare_field("rec_latest_time", want.rec.latest_time, got.rec.latest_time);
            compare_field("pad", 32'(want.pad), 32'(got.pad));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_status(fault_status_t'(m_tdata));
        end
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("fault_latch_recorder_top_test: errors");
            $finish;
        end
    end

    // Count saturation and sequence wrap need 2^32 raises and are out of reach of this run.
    task automatic test_directed_cases();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        send_request(flr_pkg::CMD_READ, 5'd5, 1'b0, 32'd0);
        send_request(flr_pkg::CMD_READ, 5'd0, 1'b1, 32'hFFFF_FFFF);
        send_request(flr_pkg::CMD_RAISE, 5'd0, 1'b1, 32'hFFFF_FFFF);
        send_request(flr_pkg::CMD_CLEAR, 5'd0, 1'b0, 32'd0);
        send_request(flr_pkg::CMD_RAISE, 5'd1, 1'b1, 32'hFFFF_FFFF);
        send_request(flr_pkg::CMD_RAISE, 5'd31, 1'b0, 32'h1234_5678);
        send_request(flr_pkg::CMD_RAISE, 5'd31, 1'b1, 32'h0BAD_F00D);
        send_request(flr_pkg::CMD_CLEAR, 5'd1, 1'b0, 32'd0);
        send_request(flr_pkg::CMD_RAISE, 5'd1, 1'b0, 32'd0);
        send_request(flr_pkg::CMD_READ, 5'd1, 1'b0, 32'd0);
        send_request(flr_pkg::CMD_CLEAR_ALL, 5'd31, 1'b0, 32'd0);
        send_request(flr_pkg::CMD_READ, 5'd31, 1'b0, 32'd0);
        send_request(flr_pkg::CMD_RAISE, 5'd31, 1'b1, 32'd0);
        send_request(flr_pkg::CMD_RAISE, 5'd16, 1'b1, 32'hAAAA_AAAA);
        send_request(flr_pkg::CMD_RAISE, 5'd2, 1'b1, 32'h5555_5555);
        send_request(flr_pkg::CMD_CLEAR, 5'd2, 1'b0, 32'd0);
        send_request(flr_pkg::CMD_CLEAR, 5'd2, 1'b0, 32'd0);
        send_request(flr_pkg::CMD_CLEAR, 5'd31, 1'b0, 32'd0);
        send_request(flr_pkg::CMD_CLEAR_ALL, 5'd0, 1'b1, 32'hFFFF_FFFF);
        send_request(flr_pkg::CMD_READ, 5'd16, 1'b0, 32'd0);
        send_request(flr_pkg::CMD_READ, 5'd31, 1'b0, 32'd0);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int unsigned count, input int unsigned tx_idle,
                                       input int unsigned rx_stall);
        tx_idle_pct = tx_idle;
        rx_stall_pct = rx_stall;
        repeat (count) send_random_request();
        wait_drained();
    endtask

    task automatic test_output_hold_off();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (300) @(posedge aclk);
                rx_hold <= 1'b0;
            end
        join_none
        repeat (40) send_random_request();
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_random_traffic(340, 0, 0);
        test_random_traffic(340, 79, 0);
        test_random_traffic(340, 0, 79);
        test_random_traffic(340, 34, 34);
        test_output_hold_off();
        if (mismatch_count == 0 && pending_status.size() == 0) begin
            $display("fault_latch_recorder_top_test: clean");
        end else begin
            $display("fault_latch_recorder_top_test: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> fault_latch_recorder_top.f
rtl/core/flr_pkg.sv
rtl/core/fault_latch_recorder_top.sv
rtl/core/flr_checker.sv
dv/fault_latch_recorder_top_test.sv
